### rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants and types of the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

   localparam int DEF_MAX_WIDTH = 2048;
   localparam logic [11:0] RESET_FRAME_WIDTH  = 12'd640;
   localparam logic [11:0] RESET_FRAME_HEIGHT = 12'd480;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // digit-by-digit root of a 17-bit value: one result bit per step
   localparam int ROOT_STEPS = 9;

   // one 3-pixel column of a single channel, index 0 is the top pixel
   typedef logic [2:0][7:0] chan_col_type;

   typedef struct packed {
      logic         edge_col;
      logic         zero;
      chan_col_type left;
      chan_col_type center;
      chan_col_type right;
   } lane_job_type;

endpackage

### rtl/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// Separable 3x3 Sobel gradient magnitude of a raster RGB stream, one lane
// per color channel, results tagged with row and column.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  req_    | in  | req_valid/ready    | one RGB pixel
//  rsp_    | out | rsp_valid/ready    | row, column, three magnitudes, last
//  csr_    | in  | csr_valid/ready    | register index and data
//
//  A pixel passes through the line store read and then, per result (0 to 3
//  results), a gradient register, a squaring register and 9 steps of the
//  shared-per-lane root unit, then the output register.
//  Reset (synchronous) clears position, column window and control state;
//  the line stores hold garbage until written. A stalled rsp_ holds the block.
//  Configuration is taken only while the block is idle.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
   parameter int MAX_WIDTH = sgm_pkg::DEF_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_pixel_blue,
   input  logic [7:0]                      req_pixel_green,
   input  logic [7:0]                      req_pixel_red,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [11:0]                     rsp_out_row,
   output logic [10:0]                     rsp_out_col,
   output logic [7:0]                      rsp_mag_blue,
   output logic [7:0]                      rsp_mag_green,
   output logic [7:0]                      rsp_mag_red,
   output logic                            rsp_last_of_run,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sgm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [11:0]                     csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int XW = (CW + 1 > 12) ? CW + 1 : 12;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_START = 5'b00100,
      ST_LANE  = 5'b01000,
      ST_SEND  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [11:0]   frame_width_ff, frame_height_ff;
   logic [11:0]   row_ff;
   logic [CW-1:0] col_ff;
   logic [23:0]   pix_ff, rd_upper_ff, rd_lower_ff;
   logic [2:0][23:0] win0_ff, win1_ff, cur_col;
   logic [2:0]    pend_ff, cur_ff, pick;
   logic          zero_row_ff;
   logic [11:0]   job_row_ff;
   logic [CW-1:0] job_col_ff;

   logic [23:0] upper_mem [MAX_WIDTH];
   logic [23:0] lower_mem [MAX_WIDTH];

   logic [XW-1:0] fw_x, w_eff;
   logic [CW-1:0] last_col;
   logic [11:0]   h_eff, last_row;
   logic          req_fire, rsp_fire, csr_fire, finish;

   sgm_pkg::lane_job_type lane_job [3];
   logic [2:0]            lane_done;
   logic [7:0]            lane_mag [3];

   // effective frame size, clamped to the legal range
   always_comb begin
      fw_x  = XW'(frame_width_ff);
      w_eff = fw_x;
      if (fw_x < XW'(3)) w_eff = XW'(3);
      if (fw_x > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
      last_col = CW'(w_eff - XW'(1));
      h_eff    = (frame_height_ff < 12'd3) ? 12'd3 : frame_height_ff;
      last_row = h_eff - 12'd1;
   end

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // column arriving with this pixel: two rows above, one above, this one
   assign cur_col = {pix_ff, rd_lower_ff, rd_upper_ff};

   // pending results in emit order: upper-left, upper edge, own bottom row
   always_comb begin
      pick = 3'b000;
      if (pend_ff[0]) pick = 3'b001;
      else if (pend_ff[1]) pick = 3'b010;
      else if (pend_ff[2]) pick = 3'b100;
   end

   // retire when no results remain
   assign finish = ((state_ff == ST_FETCH) && (pend_ff == 3'b000)) ||
                   (rsp_fire && ((pend_ff & ~cur_ff) == 3'b000));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_FETCH;
         ST_FETCH: state_in = (pend_ff == 3'b000) ? ST_IDLE : ST_START;
         ST_START: state_in = ST_LANE;
         ST_LANE:  if (lane_done[0]) state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_fire) state_in = finish ? ST_IDLE : ST_START;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= sgm_pkg::RESET_FRAME_WIDTH;
         frame_height_ff <= sgm_pkg::RESET_FRAME_HEIGHT;
         row_ff          <= '0;
         col_ff          <= '0;
         win0_ff         <= '0;
         win1_ff         <= '0;
         pend_ff         <= '0;
         rsp_valid       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            // a write to the width or height register restarts the frame
            if (csr_index == sgm_pkg::CSR_FRAME_WIDTH) begin
               frame_width_ff <= csr_data;
               row_ff <= '0;
               col_ff <= '0;
            end else if (csr_index == sgm_pkg::CSR_FRAME_HEIGHT) begin
               frame_height_ff <= csr_data;
               row_ff <= '0;
               col_ff <= '0;
            end
         end
         if (req_fire) begin
            pend_ff[0] <= (row_ff != '0) && (col_ff != '0);
            pend_ff[1] <= (row_ff != '0) && (col_ff == last_col);
            pend_ff[2] <= (row_ff == last_row);
         end
         if (rsp_fire) begin
            pend_ff <= pend_ff & ~cur_ff;
         end
         if (state_ff == ST_LANE && lane_done[0]) begin
            rsp_valid <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid <= 1'b0;
         end
         if (finish) begin
            // advance the window and the raster position
            win1_ff <= win0_ff;
            win0_ff <= cur_col;
            if (col_ff == last_col) begin
               col_ff <= '0;
               row_ff <= (row_ff >= last_row) ? 12'd0 : row_ff + 12'd1;
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
      end
   end

   // line stores: read at accept, rotate one row down in the fetch cycle
   always_ff @(posedge clock) begin
      if (req_fire) rd_upper_ff <= upper_mem[col_ff];
      if (state_ff == ST_FETCH) upper_mem[col_ff] <= rd_lower_ff;
   end

   always_ff @(posedge clock) begin
      if (req_fire) rd_lower_ff <= lower_mem[col_ff];
      if (state_ff == ST_FETCH) lower_mem[col_ff] <= pix_ff;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pix_ff      <= {req_pixel_red, req_pixel_green, req_pixel_blue};
         zero_row_ff <= (row_ff == 12'd1);
      end
      if (state_ff == ST_START) begin
         cur_ff     <= pick;
         job_row_ff <= pick[2] ? row_ff : row_ff - 12'd1;
         job_col_ff <= pick[0] ? col_ff - CW'(1) : col_ff;
      end
   end

   // per-channel job for the result being started
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 3; k++) begin
            lane_job[ch].left[k]   = win1_ff[k][8*ch +: 8];
            lane_job[ch].center[k] = win0_ff[k][8*ch +: 8];
            lane_job[ch].right[k]  = cur_col[k][8*ch +: 8];
         end
         lane_job[ch].edge_col = 1'b1;
         lane_job[ch].zero     = zero_row_ff;
         if (pick[0]) begin
            lane_job[ch].edge_col = (col_ff == CW'(1));
         end else begin
            for (int k = 0; k < 3; k++) begin
               lane_job[ch].center[k] = cur_col[k][8*ch +: 8];
            end
            if (pick[2]) lane_job[ch].zero = 1'b1;
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      sgm_lane u_lane (
         .clock (clock),
         .reset (reset),
         .start (state_ff == ST_START),
         .job   (lane_job[g]),
         .done  (lane_done[g]),
         .mag   (lane_mag[g])
      );
   end

   // merge the three lanes into the output word
   always_ff @(posedge clock) begin
      if (state_ff == ST_LANE && lane_done[0]) begin
         rsp_out_row     <= job_row_ff;
         rsp_out_col     <= 11'(job_col_ff);
         rsp_mag_blue    <= lane_mag[0];
         rsp_mag_green   <= lane_mag[1];
         rsp_mag_red     <= lane_mag[2];
         rsp_last_of_run <= ((pend_ff & ~cur_ff) == 3'b000);
      end
   end

   a_lanes_in_step : assert property (@(posedge clock) disable iff (reset)
      (lane_done[0] == lane_done[1]) && (lane_done[0] == lane_done[2]))
      else $error("channel lanes out of step");

   a_rsp_only_in_send : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_SEND))
      else $error("result shown outside send state");

   a_accept_fetches : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_FETCH))
      else $error("accepted pixel not fetched");

   a_one_job : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LANE) |-> $onehot(cur_ff))
      else $error("no single result selected");

endmodule

### rtl/sgm_lane.sv
// ----------------------------------------------------------------------------
// sgm_lane
// One color channel: Sobel gradients, squared sum and an iterative root.
// ----------------------------------------------------------------------------
module sgm_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  sgm_pkg::lane_job_type job,
   output logic                 done,
   output logic [7:0]           mag
);

   logic [7:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic [17:0] n_ff, n_in, root_ff, root_in, bit_ff, bit_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        sq_ff, run_ff, done_ff;

   logic [7:0]         vs_l, vs_c, vs_r;
   logic signed [9:0]  gx;
   logic signed [8:0]  d_l, d_c, d_r;
   logic signed [11:0] ssum, gy;
   logic [15:0]        sq_x, sq_y;

   function automatic logic [7:0] vsmooth(sgm_pkg::chan_col_type x);
      logic [9:0] s;
      s = {2'b00, x[0]} + {1'b0, x[1], 1'b0} + {2'b00, x[2]};
      return s[9:2];
   endfunction

   function automatic logic signed [8:0] vdiff(sgm_pkg::chan_col_type x);
      return $signed({1'b0, x[0]}) - $signed({1'b0, x[2]});
   endfunction

   always_comb begin
      vs_l = vsmooth(job.left);
      vs_c = vsmooth(job.center);
      vs_r = vsmooth(job.right);
      d_l  = vdiff(job.left);
      d_c  = vdiff(job.center);
      d_r  = vdiff(job.right);
      ssum = 12'(d_l) + (12'(d_c) <<< 1) + 12'(d_r);
      // divide by four, truncating toward zero
      gy = (ssum < 0) ? -((-ssum) >>> 2) : (ssum >>> 2);
      gx = $signed({2'b00, vs_r}) - $signed({2'b00, vs_l});
      if (job.edge_col) begin
         gx = $signed({2'b00, vs_c});
         gy = 12'(d_c);
      end
      ax_in = (gx < 0) ? 8'(-gx) : 8'(gx);
      ay_in = (gy < 0) ? 8'(-gy) : 8'(gy);
      if (job.zero) begin
         ax_in = '0;
         ay_in = '0;
      end
   end

   assign sq_x = ax_ff * ax_ff;
   assign sq_y = ay_ff * ay_ff;

   always_comb begin
      n_in    = n_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      if (sq_ff) begin
         n_in    = {2'b00, sq_x} + {2'b00, sq_y};
         root_in = '0;
         bit_in  = 18'h10000;
         cnt_in  = 4'(sgm_pkg::ROOT_STEPS);
      end else if (run_ff) begin
         if (n_ff >= root_ff + bit_ff) begin
            n_in    = n_ff - (root_ff + bit_ff);
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff   <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         sq_ff   <= start;
         done_ff <= run_ff && (cnt_ff == 4'd1);
         if (sq_ff) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == 4'd1) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
      n_ff    <= n_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign mag  = (root_ff > 18'd255) ? 8'hFF : root_ff[7:0];

endmodule
